// ===== src/gww_pkg.sv =====
package gww_pkg;

   // Fixed field widths.
   localparam int BYTE_W  = 8;
   localparam int WIDTH_W = 6;
   localparam int LINE_W  = 7;

   // Character codes and limits.
   localparam logic [BYTE_W-1:0]  CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0]  CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0]  CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0]  CHAR_CR    = 8'h0D;
   localparam logic [WIDTH_W-1:0] MIN_WRAP   = 6'd10;
   localparam logic [LINE_W-1:0]  LINE_SAT   = 7'd127;

   // Command broadcast from the controller to every cell of the word chain.
   typedef struct packed {
      logic               shift;
      logic               load;
      logic [WIDTH_W-1:0] wr_idx;
      logic [BYTE_W-1:0]  wr_byte;
   } cell_cmd_type;

   // Emitter phases.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PRE  = 5'b00010,
      ST_WORD = 5'b00100,
      ST_CHAR = 5'b01000,
      ST_TAIL = 5'b10000
   } emit_state_type;

   // True for space, tab, newline, vertical tab, form feed and return.
   function automatic logic is_space(input logic [BYTE_W-1:0] c);
      is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

// ===== src/gww_cell.sv =====
module gww_cell #(
   parameter int INDEX = 0
) (
   input  logic                            clock,
   input  gww_pkg::cell_cmd_type           cmd,
   input  logic [gww_pkg::BYTE_W-1:0]      next_byte,
   output logic [gww_pkg::BYTE_W-1:0]      cell_byte
);

   logic [gww_pkg::BYTE_W-1:0] byte_ff;
   logic [gww_pkg::BYTE_W-1:0] byte_in;

   // Take the neighbor's byte on a shift, or the new word byte when addressed.
   always_comb begin
      byte_in = byte_ff;
      if (cmd.shift) begin
         byte_in = next_byte;
      end else if (cmd.load && (cmd.wr_idx == gww_pkg::WIDTH_W'(INDEX))) begin
         byte_in = cmd.wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// ===== src/gww_ctrl.sv =====
module gww_ctrl #(
   parameter int WORD_MAX = 61
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gww_pkg::BYTE_W-1:0]        req_tdata,
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gww_pkg::BYTE_W-1:0]        rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [gww_pkg::WIDTH_W-1:0]       csr_wr_data,
   input  logic [gww_pkg::BYTE_W-1:0]        head_byte,
   output gww_pkg::cell_cmd_type             cell_cmd
);

   localparam logic [gww_pkg::WIDTH_W-1:0] WMAX = gww_pkg::WIDTH_W'(WORD_MAX);

   gww_pkg::emit_state_type state_ff, state_in, after_pre, after_word, after_char;

   logic [gww_pkg::WIDTH_W-1:0] wrap_ff, wrap_in;
   logic [gww_pkg::WIDTH_W-1:0] word_len_ff, word_len_in;
   logic [gww_pkg::LINE_W-1:0]  line_len_ff, line_len_in;
   logic                        prev_nl_ff, prev_nl_in;
   logic [gww_pkg::WIDTH_W-1:0] cnt_ff, cnt_in;
   logic [gww_pkg::BYTE_W-1:0]  pre_byte_ff, pre_byte_in;
   logic [gww_pkg::BYTE_W-1:0]  char_ff, char_in;
   logic                        word_en_ff, word_en_in;
   logic                        char_en_ff, char_en_in;
   logic                        tail_en_ff, tail_en_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gww_pkg::BYTE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        accept, emit_go, ws, is_nl, dump, fits, pre_en;
   logic [gww_pkg::BYTE_W-1:0]  emit_byte;
   logic [gww_pkg::LINE_W:0]    need;
   gww_pkg::emit_state_type     emit_next;

   assign req_tready = (state_ff == gww_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign emit_go    = (state_ff != gww_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   // Classify the incoming item against the current line and word.
   assign ws    = gww_pkg::is_space(req_tdata);
   assign is_nl = (req_tdata == gww_pkg::CHAR_NL);
   assign dump  = (word_len_ff >= wrap_ff) || (word_len_ff >= WMAX);
   assign need  = {1'b0, line_len_ff} + {2'b00, word_len_ff}
                + {{gww_pkg::LINE_W{1'b0}}, (line_len_ff != '0)};
   assign fits  = need <= {2'b00, wrap_ff};

   // Phase order after each phase, skipping the disabled ones.
   always_comb begin
      after_char = tail_en_ff ? gww_pkg::ST_TAIL : gww_pkg::ST_IDLE;
      after_word = char_en_ff ? gww_pkg::ST_CHAR : after_char;
      after_pre  = word_en_ff ? gww_pkg::ST_WORD : after_word;
   end

   // Byte driven out in the current phase and the phase that follows it.
   always_comb begin
      emit_byte = gww_pkg::CHAR_NL;
      emit_next = gww_pkg::ST_IDLE;
      case (state_ff)
         gww_pkg::ST_PRE: begin
            emit_byte = pre_byte_ff;
            emit_next = after_pre;
         end
         gww_pkg::ST_WORD: begin
            emit_byte = head_byte;
            emit_next = (cnt_ff == gww_pkg::WIDTH_W'(1)) ? after_word : gww_pkg::ST_WORD;
         end
         gww_pkg::ST_CHAR: begin
            emit_byte = char_ff;
            emit_next = after_char;
         end
         gww_pkg::ST_TAIL: begin
            emit_byte = gww_pkg::CHAR_NL;
            emit_next = gww_pkg::ST_IDLE;
         end
         default: begin
            emit_byte = gww_pkg::CHAR_NL;
            emit_next = gww_pkg::ST_IDLE;
         end
      endcase
   end

   // Plan the output of an accepted item and update the line state.
   always_comb begin
      word_len_in = word_len_ff;
      line_len_in = line_len_ff;
      prev_nl_in  = prev_nl_ff;
      pre_byte_in = pre_byte_ff;
      char_in     = char_ff;
      word_en_in  = word_en_ff;
      char_en_in  = char_en_ff;
      tail_en_in  = tail_en_ff;
      pre_en      = 1'b0;
      cell_cmd.shift   = emit_go && (state_ff == gww_pkg::ST_WORD);
      cell_cmd.load    = 1'b0;
      cell_cmd.wr_idx  = word_len_ff;
      cell_cmd.wr_byte = req_tdata;
      if (accept) begin
         word_en_in  = 1'b0;
         char_en_in  = 1'b0;
         tail_en_in  = 1'b0;
         char_in     = req_tdata;
         pre_byte_in = gww_pkg::CHAR_NL;
         if (req_tuser) begin
            // End of text: flush the word, then a closing newline.
            if (word_len_ff != '0) begin
               word_en_in = 1'b1;
               if (!fits) begin
                  pre_en = 1'b1;
               end else if (line_len_ff != '0) begin
                  pre_en      = 1'b1;
                  pre_byte_in = gww_pkg::CHAR_SPACE;
               end
            end
            tail_en_in  = 1'b1;
            word_len_in = '0;
            line_len_in = '0;
            prev_nl_in  = 1'b0;
         end else begin
            prev_nl_in = is_nl;
            if (!ws) begin
               if (!dump) begin
                  cell_cmd.load = 1'b1;
                  word_len_in   = word_len_ff + 1'b1;
               end else begin
                  // Word too long: it goes out on a line of its own.
                  pre_en      = 1'b1;
                  word_en_in  = 1'b1;
                  char_en_in  = 1'b1;
                  tail_en_in  = 1'b1;
                  word_len_in = '0;
                  line_len_in = '0;
               end
            end else if (prev_nl_ff) begin
               if (is_nl) begin
                  // Paragraph break.
                  pre_en      = 1'b1;
                  tail_en_in  = 1'b1;
                  line_len_in = '0;
               end else if ((line_len_ff != '0) && (line_len_ff < gww_pkg::LINE_SAT)) begin
                  line_len_in = line_len_ff + 1'b1;
               end
            end else if (word_len_ff != '0) begin
               word_en_in  = 1'b1;
               word_len_in = '0;
               if (fits) begin
                  if (line_len_ff != '0) begin
                     pre_en      = 1'b1;
                     pre_byte_in = gww_pkg::CHAR_SPACE;
                  end
                  line_len_in = need[gww_pkg::LINE_W-1:0];
               end else begin
                  pre_en      = 1'b1;
                  line_len_in = {1'b0, word_len_ff};
               end
            end
         end
      end
   end

   // Phase sequencing and the word byte counter.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         cnt_in = word_len_ff;
         if (pre_en) begin
            state_in = gww_pkg::ST_PRE;
         end else if (word_en_in) begin
            state_in = gww_pkg::ST_WORD;
         end else if (tail_en_in) begin
            state_in = gww_pkg::ST_TAIL;
         end
      end else if (emit_go) begin
         state_in = emit_next;
         if (state_ff == gww_pkg::ST_WORD) begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // Output register decouples the emitter from the result channel.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = (emit_next == gww_pkg::ST_IDLE);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Width register; out-of-range values fall back to the maximum.
   always_comb begin
      wrap_in = wrap_ff;
      if (csr_wr_en) begin
         if ((csr_wr_data < gww_pkg::MIN_WRAP) || (csr_wr_data > WMAX)) begin
            wrap_in = WMAX;
         end else begin
            wrap_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gww_pkg::ST_IDLE;
         wrap_ff      <= WMAX;
         word_len_ff  <= '0;
         line_len_ff  <= '0;
         prev_nl_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wrap_ff      <= wrap_in;
         word_len_ff  <= word_len_in;
         line_len_ff  <= line_len_in;
         prev_nl_ff   <= prev_nl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pre_byte_ff <= pre_byte_in;
      char_ff     <= char_in;
      word_en_ff  <= word_en_in;
      char_en_ff  <= char_en_in;
      tail_en_ff  <= tail_en_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/greedy_word_wrap_stream.sv =====
// An item that produces no bytes leaves the block idle; for one that produces bytes,
// the emitter loads one byte per cycle into the output register when it is empty or taken.
// An item's first byte passes the phase register, then the output register; the next item
// is accepted once the last byte is in the output register, even if not yet taken.
// Reset clears the line state, sets the wrap width to WORD_MAX and leaves the word
// cells uninitialized; the block is ready in the cycle after reset drops.
module greedy_word_wrap_stream #(
   parameter int WORD_MAX = 61
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gww_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] text_byte
   input  logic                          req_tuser,   // [0] end_of_text
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gww_pkg::BYTE_W-1:0]    rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tlast,   // last_of_run
   input  logic                          csr_wr_en,
   input  logic [gww_pkg::WIDTH_W-1:0]   csr_wr_data  // wrap_width
);

   gww_pkg::cell_cmd_type       cell_cmd;
   logic [gww_pkg::BYTE_W-1:0]  cell_data [WORD_MAX];

   gww_ctrl #(
      .WORD_MAX(WORD_MAX)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_byte   (cell_data[0]),
      .cell_cmd    (cell_cmd)
   );

   // Word chain: bytes are written by position and shift toward cell zero as they go out.
   for (genvar i = 0; i < WORD_MAX; i++) begin : g_cell
      logic [gww_pkg::BYTE_W-1:0] next_byte;
      if (i == WORD_MAX - 1) begin : g_end
         assign next_byte = '0;
      end else begin : g_mid
         assign next_byte = cell_data[i+1];
      end
      gww_cell #(
         .INDEX(i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cell_cmd),
         .next_byte (next_byte),
         .cell_byte (cell_data[i])
      );
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import gww_pkg::*;

   localparam int WORD_CAP   = 61;
   localparam int WATCH_MAX  = 2000;
   localparam int HOLD_LONG  = 300;
   localparam logic [BYTE_W-1:0] CHAR_VT = 8'h0B;
   localparam logic [BYTE_W-1:0] CHAR_FF = 8'h0C;

   typedef struct packed {
      logic [BYTE_W-1:0] ch;
      logic              tail;
   } text_out_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [BYTE_W-1:0]   req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [BYTE_W-1:0]   rsp_tdata;
   logic                rsp_tlast;
   logic                csr_wr_en;
   logic [WIDTH_W-1:0]  csr_wr_data;

   // Predicted wrapper state and the bytes it still owes.
   logic [BYTE_W-1:0] word_buf [0:WORD_CAP-1];
   int                word_len;
   int                line_len;
   bit                after_nl;
   int                wrap_w;
   text_out_type      wrapped_text[$];

   int  errors;
   int  items_taken;
   int  bytes_checked;
   int  width_writes;
   int  rsp_wait;
   int  rsp_hold;
   int  stall_count;
   bit  in_idle;
   bit  out_idle;

   greedy_word_wrap_stream DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [7:0] text_byte
      .req_tuser   (req_tuser),   // [0] end_of_text
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [7:0] out_byte
      .rsp_tlast   (rsp_tlast),   // last_of_run
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)  // wrap_width
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit blank_char(input logic [BYTE_W-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   // Width register update, with the fallback for values outside 10..61.
   function automatic void apply_width(input logic [WIDTH_W-1:0] v);
      if ((v < MIN_WRAP) || (v > WORD_CAP))
         wrap_w = WORD_CAP;
      else
         wrap_w = int'(v);
   endfunction

   // Computes the bytes one input item produces and queues them for checking.
   function automatic void wrap_predict(input logic [BYTE_W-1:0] c, input logic eot);
      logic [BYTE_W-1:0] burst[$];
      bit                fit;
      text_out_type      entry;
      fit = (line_len + word_len + ((line_len > 0) ? 1 : 0)) <= wrap_w;
      if (eot) begin
         // Flush the pending word, then close the text with a newline.
         if (word_len > 0) begin
            if (fit) begin
               if (line_len > 0) burst.push_back(CHAR_SPACE);
            end else begin
               burst.push_back(CHAR_NL);
            end
            for (int i = 0; i < word_len; i++) burst.push_back(word_buf[i]);
         end
         burst.push_back(CHAR_NL);
         word_len = 0;
         line_len = 0;
         after_nl = 0;
      end else begin
         if (!blank_char(c)) begin
            if ((word_len < wrap_w) && (word_len < WORD_CAP)) begin
               word_buf[word_len] = c;
               word_len++;
            end else begin
               // Overlong word goes out on a line of its own.
               burst.push_back(CHAR_NL);
               for (int i = 0; i < word_len; i++) burst.push_back(word_buf[i]);
               burst.push_back(c);
               burst.push_back(CHAR_NL);
               word_len = 0;
               line_len = 0;
            end
         end else if (after_nl) begin
            if (c == CHAR_NL) begin
               line_len = 0;
               burst.push_back(CHAR_NL);
               burst.push_back(CHAR_NL);
            end else if ((line_len > 0) && (line_len < LINE_SAT)) begin
               line_len++;
            end
         end else if (word_len > 0) begin
            if (fit) begin
               if (line_len > 0) begin
                  burst.push_back(CHAR_SPACE);
                  line_len++;
               end
               for (int i = 0; i < word_len; i++) burst.push_back(word_buf[i]);
               line_len += word_len;
            end else begin
               burst.push_back(CHAR_NL);
               for (int i = 0; i < word_len; i++) burst.push_back(word_buf[i]);
               line_len = word_len;
            end
            word_len = 0;
         end
         after_nl = (c == CHAR_NL);
      end
      foreach (burst[i]) begin
         entry.ch   = burst[i];
         entry.tail = (i == burst.size() - 1);
         wrapped_text.push_back(entry);
      end
   endfunction

   function automatic void report_error(input string what, input text_out_type want);
      errors++;
      if (errors <= 10)
         $display("tb: %s at %0t: expected byte %02h last %0b, got byte %02h last %0b",
                  what, $time, want.ch, want.tail, rsp_tdata, rsp_tlast);
   endfunction

   // Input acceptance feeds the predictor; each output item is checked in order.
   always @(posedge clock) begin
      text_out_type want;
      if (!reset) begin
         if (csr_wr_en) apply_width(csr_wr_data);
         if (req_tvalid && req_tready) begin
            wrap_predict(req_tdata, req_tuser);
            items_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            bytes_checked++;
            if (wrapped_text.size() == 0) begin
               want = '0;
               report_error("unexpected output", want);
            end else begin
               want = wrapped_text.pop_front();
               if ((want.ch !== rsp_tdata) || (want.tail !== rsp_tlast))
                  report_error("mismatch", want);
            end
            rsp_wait = out_idle ? $urandom_range(0, 5) : 0;
         end
      end
   end

   // Receiver: random stall after each item, plus a long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when work is pending but nothing moves.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (!req_tvalid && (wrapped_text.size() == 0) && (rsp_hold == 0)))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= WATCH_MAX) begin
         $display("tb: no progress for %0d cycles", WATCH_MAX);
         $display("tb: FAIL");
         $finish;
      end
   end

   // Offers one item after a random gap and waits until it is taken.
   task automatic send_char(input logic [BYTE_W-1:0] b, input logic eot);
      int gap;
      gap = in_idle ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= eot;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_end();
      send_char(BYTE_W'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   function automatic logic [BYTE_W-1:0] rand_word_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255)); while (blank_char(b));
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] rand_blank();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return CHAR_SPACE;
         4, 5:       return CHAR_NL;
         6:          return CHAR_TAB;
         default:    return BYTE_W'($urandom_range(CHAR_VT, CHAR_CR));
      endcase
   endfunction

   task automatic send_word(input int len);
      for (int i = 0; i < len; i++) send_char(rand_word_byte(), 1'b0);
   endtask

   // Stops offering, waits for every owed byte, then lets the block settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (wrapped_text.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      width_writes++;
   endtask

   // Every whitespace code, byte extremes, paragraph breaks and both flush kinds.
   task automatic test_directed();
      in_idle  = 0;
      out_idle = 0;
      send_char("a", 1'b0);
      send_char("b", 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(CHAR_SPACE, 1'b0);
      send_string("cd");
      send_char(CHAR_TAB, 1'b0);
      send_char("e", 1'b0);
      send_char(CHAR_NL, 1'b0);
      send_char(CHAR_NL, 1'b0);
      send_char("f", 1'b0);
      send_char(CHAR_NL, 1'b0);
      // Whitespace right after a newline only grows the line count.
      send_char(CHAR_VT, 1'b0);
      send_char(CHAR_FF, 1'b0);
      send_char(CHAR_CR, 1'b0);
      send_string("gh");
      send_end();
      send_end();
      send_char(8'h7F, 1'b0);
      send_char(8'h80, 1'b0);
      send_end();
      wait_idle();
   endtask

   // Narrow and widest settings, fallback on bad values, width lowered mid-word.
   task automatic test_width_settings();
      in_idle  = 1;
      out_idle = 1;
      write_width(6'd10);
      send_string("abcdefgh xyz ");
      send_string("0123456789A");
      send_string("abcdef ghijk");
      send_end();
      wait_idle();
      // Out-of-range values all fall back to the widest setting.
      write_width(6'd9);
      send_word(12);
      send_char(CHAR_SPACE, 1'b0);
      send_end();
      wait_idle();
      write_width(6'd63);
      write_width(6'd62);
      send_word(12);
      send_char(CHAR_SPACE, 1'b0);
      send_word(12);
      send_end();
      wait_idle();
      write_width(6'd0);
      send_word(15);
      wait_idle();
      write_width(6'd10);
      send_char("z", 1'b0);
      send_end();
      wait_idle();
      // A word of exactly the width fits; one byte more dumps it.
      write_width(6'd61);
      send_word(61);
      send_char(CHAR_SPACE, 1'b0);
      send_word(62);
      send_end();
      wait_idle();
   endtask

   // Mostly well-formed text with random content under several widths.
   task automatic test_random_text();
      int target;
      int sent;
      int pick;
      int len;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       write_width(6'd10);
            1:       write_width(6'd61);
            2:       write_width(WIDTH_W'($urandom_range(0, 63)));
            default: write_width(WIDTH_W'($urandom_range(10, 61)));
         endcase
         in_idle  = (phase != 0) && ($urandom_range(0, 3) != 0);
         out_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
         target = 8;
         sent   = 0;
         while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_char(BYTE_W'($urandom_range(0, 255)), 1'b0);
               sent++;
            end else if (pick < 12) begin
               send_end();
               sent++;
            end else begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70)
                                                 : $urandom_range(1, 12);
               send_word(len);
               send_char(rand_blank(), 1'b0);
               sent += len + 1;
            end
         end
         send_end();
         wait_idle();
      end
   endtask

   // Receiver holds off for a long stretch while text keeps coming.
   task automatic test_backpressure();
      in_idle  = 0;
      out_idle = 1;
      write_width(6'd20);
      @(posedge clock);
      rsp_hold = HOLD_LONG;
      for (int i = 0; i < 6; i++) begin
         send_word($urandom_range(3, 12));
         send_char(rand_blank(), 1'b0);
      end
      send_end();
      wait_idle();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      word_len    = 0;
      line_len    = 0;
      after_nl    = 0;
      wrap_w      = WORD_CAP;
      errors      = 0;
      items_taken = 0;
      bytes_checked = 0;
      width_writes  = 0;
      rsp_wait    = 0;
      rsp_hold    = 0;
      stall_count = 0;
      in_idle     = 0;
      out_idle    = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_width_settings();
      test_random_text();
      test_backpressure();

      wait_idle();
      repeat (10) @(posedge clock);
      if (wrapped_text.size() > 0) errors++;
      $display("tb: %0d text items in, %0d wrapped bytes checked, %0d width writes",
               items_taken, bytes_checked, width_writes);
      $display("tb: covered widths 10 to 61, fallback values, word dumps and long stalls");
      if (errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/gww_pkg.sv
src/gww_cell.sv
src/gww_ctrl.sv
src/greedy_word_wrap_stream.sv
tb/tb.sv
